// ===== rtl/swgc_pkg.sv =====
// Package for the sliding window group counter: widths, codes and item types.
`timescale 1ns / 1ps
`default_nettype none
package swgc_pkg;

    localparam int TIME_W     = 40;
    localparam int GRP_W      = 4;
    localparam int MBR_W      = 8;
    localparam int AMT_W      = 10;
    localparam int OP_W       = 2;
    localparam int VAL_W      = 18;
    localparam int DIST_W     = 9;

    localparam int GROUPS     = 16;
    localparam int MEMBERS    = 256;
    localparam int PAIRS      = GROUPS * MEMBERS;
    localparam int PAIR_AW    = GRP_W + MBR_W;

    localparam int FIFO_DEPTH = 256;
    localparam int FIFO_AW    = 8;
    localparam int CNT_W      = FIFO_AW + 1;

    localparam logic [TIME_W-1:0] WINDOW_RESET = 40'd86400;

    localparam logic [OP_W-1:0] OP_BOOK      = 2'd0;
    localparam logic [OP_W-1:0] OP_QRY_DIST  = 2'd1;
    localparam logic [OP_W-1:0] OP_QRY_TOTAL = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] time_req;
        logic [GRP_W-1:0]  group;
        logic [MBR_W-1:0]  member;
        logic [AMT_W-1:0]  amount;
    } t_in_item;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             status;
    } t_out_item;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [GRP_W-1:0]  grp;
        logic [MBR_W-1:0]  mbr;
        logic [AMT_W-1:0]  amt;
    } t_event;

    // Control from the sequencer to the tally unit.
    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic             add;
        logic [GRP_W-1:0] grp;
        logic [MBR_W-1:0] mbr;
        logic [AMT_W-1:0] amt;
    } t_adj_ctl;

endpackage
`default_nettype wire

// ===== rtl/swgc_tally.sv =====
// Per-pair amount memory with group totals and distinct counts, updated by read-modify-write.
`timescale 1ns / 1ps
`default_nettype none
module swgc_tally (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire swgc_pkg::t_adj_ctl         i_adj,
    output logic [swgc_pkg::VAL_W-1:0]      o_total,
    output logic [swgc_pkg::DIST_W-1:0]     o_distinct,
    output logic                            o_clearing
);

    logic [swgc_pkg::VAL_W-1:0]   r_pair_mem [swgc_pkg::PAIRS];
    logic [swgc_pkg::VAL_W-1:0]   r_pair_q;
    logic [swgc_pkg::VAL_W-1:0]   r_total [swgc_pkg::GROUPS];
    logic [swgc_pkg::DIST_W-1:0]  r_dist [swgc_pkg::GROUPS];
    logic [swgc_pkg::PAIR_AW-1:0] r_clr_cnt;
    logic                         r_clearing;

    logic [swgc_pkg::PAIR_AW-1:0] w_pair_addr;
    logic [swgc_pkg::VAL_W-1:0]   w_amt_ext;
    logic [swgc_pkg::VAL_W-1:0]   n_pair;
    logic [swgc_pkg::VAL_W-1:0]   n_total;
    logic [swgc_pkg::DIST_W-1:0]  n_dist;

    assign w_pair_addr = {i_adj.grp, i_adj.mbr};
    assign w_amt_ext   = {{(swgc_pkg::VAL_W - swgc_pkg::AMT_W){1'b0}}, i_adj.amt};
    assign o_total     = r_total[i_adj.grp];
    assign o_distinct  = r_dist[i_adj.grp];
    assign o_clearing  = r_clearing;

    always_comb begin
        if (i_adj.add) begin
            n_pair  = r_pair_q + w_amt_ext;
            n_total = o_total + w_amt_ext;
        end else begin
            n_pair  = r_pair_q - w_amt_ext;
            n_total = o_total - w_amt_ext;
        end
        // The distinct count moves only when a pair crosses between zero and nonzero.
        if (r_pair_q == '0 && n_pair != '0) begin
            n_dist = o_distinct + 1'b1;
        end else if (r_pair_q != '0 && n_pair == '0) begin
            n_dist = o_distinct - 1'b1;
        end else begin
            n_dist = o_distinct;
        end
    end

    // After reset the whole pair memory is swept to zero, one entry a cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == '1) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_pair_mem[r_clr_cnt] <= '0;
        end else if (i_adj.wr_en) begin
            r_pair_mem[w_pair_addr] <= n_pair;
        end
        if (i_adj.rd_en) begin
            r_pair_q <= r_pair_mem[w_pair_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < swgc_pkg::GROUPS; i++) begin
                r_total[i] <= '0;
                r_dist[i]  <= '0;
            end
        end else if (i_adj.wr_en) begin
            r_total[i_adj.grp] <= n_total;
            r_dist[i_adj.grp]  <= n_dist;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sliding_window_group_counter.sv =====
// Top level of the sliding window group counter: event FIFO, expiry sequencer and result register.
//
//   channel  direction  handshake                     payload
//   in       input      i_in_valid  / o_in_stall      i_in_data  (t_in_item)
//   out      output     o_out_valid / i_out_stall     o_out_data (t_out_item)
//   cfg      input      i_cfg_we                      i_cfg_data (window length)
//
// A query is answered straight from idle. A book passes ADJ_RD, ADJ_WR and EXP_CHK, then, for
// each event that it expires, EXP_CMP, ADJ_RD, ADJ_WR and EXP_CHK again, and ends with EXP_CMP
// and DONE, or with DONE alone when the queue is empty or the window reaches back before time
// zero. Every table update reads the pair-amount memory and then writes it in the next cycle.
// After reset a sweep zeroes the pair-amount memory; no request is taken
// meanwhile, though the window register may be written.
// A new request is taken only while the sequencer is idle and the result register is free
// or being emptied.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_group_counter (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire swgc_pkg::t_in_item              i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output swgc_pkg::t_out_item                  o_out_data,
    input  wire logic                            i_cfg_we,
    input  wire logic [swgc_pkg::TIME_W-1:0]     i_cfg_data
);

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_ADJ_RD  = 3'd2;
    localparam logic [2:0] S_ADJ_WR  = 3'd3;
    localparam logic [2:0] S_EXP_CHK = 3'd4;
    localparam logic [2:0] S_EXP_CMP = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0]                      r_state,   n_state;
    logic [swgc_pkg::FIFO_AW-1:0]    r_head,    n_head;
    logic [swgc_pkg::CNT_W-1:0]      r_count,   n_count;
    logic                            r_exp_ok,  n_exp_ok;
    logic                            r_out_valid, n_out_valid;
    logic [swgc_pkg::TIME_W-1:0]     r_window;
    logic [swgc_pkg::TIME_W-1:0]     r_limit,   n_limit;
    swgc_pkg::t_out_item             r_out,     n_out;
    logic                            r_adj_add, n_adj_add;
    logic [swgc_pkg::GRP_W-1:0]      r_adj_grp, n_adj_grp;
    logic [swgc_pkg::MBR_W-1:0]      r_adj_mbr, n_adj_mbr;
    logic [swgc_pkg::AMT_W-1:0]      r_adj_amt, n_adj_amt;

    swgc_pkg::t_event                r_fifo [swgc_pkg::FIFO_DEPTH];
    swgc_pkg::t_event                r_evt_q;

    logic                            w_in_acc;
    logic                            w_out_free;
    logic                            w_full;
    logic                            w_fifo_we;
    logic [swgc_pkg::FIFO_AW-1:0]    w_wr_idx;
    swgc_pkg::t_event                w_evt_in;
    logic [swgc_pkg::TIME_W:0]       w_diff;
    swgc_pkg::t_adj_ctl              w_adj;
    logic [swgc_pkg::VAL_W-1:0]      w_total;
    logic [swgc_pkg::DIST_W-1:0]     w_distinct;
    logic                            w_clearing;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE) || !w_out_free;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_full    = (r_count >= swgc_pkg::CNT_W'(swgc_pkg::FIFO_DEPTH));
    assign w_wr_idx  = r_head + r_count[swgc_pkg::FIFO_AW-1:0];
    assign w_fifo_we = w_in_acc && (i_in_data.op == swgc_pkg::OP_BOOK) && !w_full;
    assign w_evt_in  = '{stamp: i_in_data.time_req, grp: i_in_data.group,
                         mbr: i_in_data.member, amt: i_in_data.amount};

    // The borrow of this subtraction says whether the window reaches back before time zero.
    assign w_diff = {1'b0, i_in_data.time_req} - {1'b0, r_window};

    // While idle the tally is addressed by the incoming request so that queries read it.
    always_comb begin
        w_adj.rd_en = (r_state == S_ADJ_RD);
        w_adj.wr_en = (r_state == S_ADJ_WR);
        w_adj.add   = r_adj_add;
        w_adj.grp   = (r_state == S_IDLE) ? i_in_data.group : r_adj_grp;
        w_adj.mbr   = r_adj_mbr;
        w_adj.amt   = r_adj_amt;
    end

    swgc_tally u_tally (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adj      (w_adj),
        .o_total    (w_total),
        .o_distinct (w_distinct),
        .o_clearing (w_clearing)
    );

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_exp_ok    = r_exp_ok;
        n_limit     = r_limit;
        n_out       = r_out;
        n_adj_add   = r_adj_add;
        n_adj_grp   = r_adj_grp;
        n_adj_mbr   = r_adj_mbr;
        n_adj_amt   = r_adj_amt;
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            S_CLEAR: begin
                if (!w_clearing) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    case (i_in_data.op)
                        swgc_pkg::OP_BOOK: begin
                            if (w_full) begin
                                n_out       = '{value: '0, status: 1'b1};
                                n_out_valid = 1'b1;
                            end else begin
                                n_count   = r_count + 1'b1;
                                n_limit   = w_diff[swgc_pkg::TIME_W-1:0];
                                n_exp_ok  = !w_diff[swgc_pkg::TIME_W];
                                n_adj_add = 1'b1;
                                n_adj_grp = i_in_data.group;
                                n_adj_mbr = i_in_data.member;
                                n_adj_amt = i_in_data.amount;
                                n_state   = S_ADJ_RD;
                            end
                        end
                        swgc_pkg::OP_QRY_DIST: begin
                            n_out = '{value: swgc_pkg::VAL_W'(w_distinct), status: 1'b0};
                            n_out_valid = 1'b1;
                        end
                        swgc_pkg::OP_QRY_TOTAL: begin
                            n_out       = '{value: w_total, status: 1'b0};
                            n_out_valid = 1'b1;
                        end
                        default: begin
                            n_out       = '{value: '0, status: 1'b0};
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_ADJ_RD: begin
                n_state = S_ADJ_WR;
            end
            S_ADJ_WR: begin
                n_state = S_EXP_CHK;
            end
            S_EXP_CHK: begin
                if (!r_exp_ok || r_count == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_EXP_CMP;
                end
            end
            S_EXP_CMP: begin
                // Expiry stops at the first head entry that is still inside the window.
                if (r_evt_q.stamp > r_limit) begin
                    n_state = S_DONE;
                end else begin
                    n_adj_add = 1'b0;
                    n_adj_grp = r_evt_q.grp;
                    n_adj_mbr = r_evt_q.mbr;
                    n_adj_amt = r_evt_q.amt;
                    n_head    = r_head + 1'b1;
                    n_count   = r_count - 1'b1;
                    n_state   = S_ADJ_RD;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out       = '{value: '0, status: 1'b0};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_head      <= '0;
            r_count     <= '0;
            r_exp_ok    <= 1'b0;
            r_out_valid <= 1'b0;
            r_window    <= swgc_pkg::WINDOW_RESET;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_exp_ok    <= n_exp_ok;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_window <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit   <= n_limit;
        r_out     <= n_out;
        r_adj_add <= n_adj_add;
        r_adj_grp <= n_adj_grp;
        r_adj_mbr <= n_adj_mbr;
        r_adj_amt <= n_adj_amt;
    end

    always_ff @(posedge i_clk) begin
        if (w_fifo_we) begin
            r_fifo[w_wr_idx] <= w_evt_in;
        end
        if (r_state == S_EXP_CHK) begin
            r_evt_q <= r_fifo[r_head];
        end
    end

endmodule
`default_nettype wire
